### hw/rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types, codes and constants of the program-only flash controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  localparam int unsigned FlashBytesDefault = 524288;
  localparam int unsigned OffsetW           = 19;
  localparam int unsigned DataW             = 32;
  localparam int unsigned ByteW             = 8;
  localparam int unsigned NumLanes          = 4;

  typedef logic [1:0] op_t;
  typedef logic [1:0] size_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_READ       = 2'd0;
  localparam op_t OP_WRITE      = 2'd1;
  localparam op_t OP_CLEAR_CTRL = 2'd2;
  localparam op_t OP_RSVD       = 2'd3;

  localparam size_t SIZE_BYTE = 2'd0;
  localparam size_t SIZE_HALF = 2'd1;
  localparam size_t SIZE_WORD = 2'd2;
  localparam size_t SIZE_RSVD = 2'd3;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_BAD_SIZE   = 2'd1;
  localparam status_t ST_BAD_ACCESS = 2'd2;
  localparam status_t ST_UNHANDLED  = 2'd3;

  localparam logic REGION_FLASH = 1'b0;
  localparam logic REGION_REGS  = 1'b1;

  localparam logic [OffsetW-1:0] RegReady  = 19'h00400;
  localparam logic [OffsetW-1:0] RegConfig = 19'h00504;

  localparam logic [ByteW-1:0] ErasedByte = 8'hFF;

endpackage

`default_nettype wire

### hw/rtl/fpc_if.sv
// ----------------------------------------------------------------------------
// fpc_if
// Request and response channels of the flash controller (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface fpc_req_if;
  import fpc_pkg::*;

  logic                 valid;
  logic                 ready;
  op_t                  op;
  size_t                access_size;
  logic                 region;
  logic [OffsetW-1:0]   offset;
  logic [DataW-1:0]     write_data;

  modport source (
    output valid, op, access_size, region, offset, write_data,
    input  ready
  );

  modport sink (
    input  valid, op, access_size, region, offset, write_data,
    output ready
  );
endinterface

interface fpc_rsp_if;
  import fpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  status_t          status;

  modport source (
    output valid, read_data, status,
    input  ready
  );

  modport sink (
    input  valid, read_data, status,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/flash_program_only_controller_top.sv
// ----------------------------------------------------------------------------
// flash_program_only_controller_top
// Program-only NOR flash controller: flash array reads and word programs,
// READY and CONFIG registers.
// ----------------------------------------------------------------------------
// The array sits in four byte-lane RAMs, so any byte, halfword or word access,
// aligned or not, touches each lane at most once. An access is accepted when
// req_i.ready is high; the lanes are read on that edge, and in the lookup state
// that follows the result is formed, programmed bytes (old AND new) are written
// back and the response register is loaded, once that register is empty or
// being taken. The read-then-write of the lane RAMs sets this state: ready
// stays low in it, and the state lasts while the response register is still
// full. After reset the block erases the array to 0xFF, one row of all four
// lanes per cycle, through all LaneDepth rows (131072 at the default size),
// before it takes the first access.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_program_only_controller_top #(
  parameter int unsigned FLASH_BYTES = fpc_pkg::FlashBytesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpc_req_if.sink   req_i,
  fpc_rsp_if.source rsp_o
);
  import fpc_pkg::*;

  localparam int unsigned LaneDepth = (FLASH_BYTES + NumLanes - 1) / NumLanes;
  localparam int unsigned RowW      = $clog2(LaneDepth);
  localparam int unsigned AddrW     = OffsetW + 2;
  localparam logic [RowW-1:0]  LastRow    = RowW'(LaneDepth - 1);
  localparam logic [AddrW-1:0] FlashLimit = AddrW'(FLASH_BYTES);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLookup
  } state_e;

  function automatic logic [RowW-1:0] lane_row(logic [OffsetW-1:0] off, logic [1:0] lane);
    logic [AddrW-1:0] byte_addr;
    byte_addr = AddrW'(off) + AddrW'(2'(lane - off[1:0]));
    return byte_addr[RowW+1:2];
  endfunction

  state_e             state_q;
  logic [RowW-1:0]    clr_row_q;
  logic [DataW-1:0]   ctrl_q;
  logic               out_valid_q;
  logic [DataW-1:0]   out_data_q;
  status_t            out_status_q;

  op_t                op_q;
  size_t              size_q;
  logic               region_q;
  logic [OffsetW-1:0] offset_q;
  logic [DataW-1:0]   wdata_q;

  logic                              accept;
  logic                              clearing;
  logic                              finish;
  logic [NumLanes-1:0][ByteW-1:0]    lane_rd;
  logic [NumLanes-1:0][ByteW-1:0]    lane_wd;
  logic [NumLanes-1:0][ByteW-1:0]    wbytes;
  logic [NumLanes-1:0][ByteW-1:0]    flash_val;
  logic [2:0]                        width;
  logic [AddrW-1:0]                  end_addr;
  logic                              in_range;
  logic [DataW-1:0]                  rd_d;
  status_t                           st_d;
  logic                              do_prog;
  logic                              ctrl_we;
  logic                              ctrl_clr;

  assign accept   = req_i.valid && req_i.ready;
  assign clearing = (state_q == StClear);
  assign finish   = (state_q == StLookup) && (!out_valid_q || rsp_o.ready);

  assign req_i.ready     = (state_q == StIdle);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;
  assign rsp_o.status    = out_status_q;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    fpc_ram #(
      .Width (ByteW),
      .Depth (LaneDepth)
    ) u_lane_ram (
      .clk_i   (clk_i),
      .we_i    (clearing || (finish && do_prog)),
      .waddr_i (clearing ? clr_row_q : lane_row(offset_q, 2'(l))),
      .wdata_i (clearing ? ErasedByte : lane_wd[l]),
      .re_i    (accept),
      .raddr_i (lane_row(req_i.offset, 2'(l))),
      .rdata_o (lane_rd[l])
    );
  end

  assign wbytes   = wdata_q;
  assign width    = 3'(1) << size_q;
  assign end_addr = AddrW'(offset_q) + AddrW'(width);
  assign in_range = (end_addr <= FlashLimit);

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      flash_val[i] = (3'(i) < width) ? lane_rd[2'(offset_q[1:0] + 2'(i))] : '0;
      lane_wd[i]   = lane_rd[i] & wbytes[2'(2'(i) - offset_q[1:0])];
    end
  end

  always_comb begin
    rd_d     = '0;
    st_d     = ST_OK;
    do_prog  = 1'b0;
    ctrl_we  = 1'b0;
    ctrl_clr = 1'b0;
    if (op_q == OP_CLEAR_CTRL) begin
      ctrl_clr = 1'b1;
    end else if (op_q == OP_RSVD) begin
      st_d = ST_UNHANDLED;
    end else if (size_q == SIZE_RSVD) begin
      st_d = ST_BAD_SIZE;
    end else if (region_q == REGION_FLASH) begin
      if (!in_range) begin
        st_d = ST_UNHANDLED;
      end else if (op_q == OP_READ) begin
        rd_d = flash_val;
      end else if (size_q != SIZE_WORD) begin
        st_d = ST_BAD_SIZE;
      end else if (!ctrl_q[0]) begin
        st_d = ST_BAD_ACCESS;
      end else begin
        do_prog = 1'b1;
      end
    end else if (offset_q == RegReady) begin
      if (op_q != OP_READ) begin
        st_d = ST_BAD_ACCESS;
      end else begin
        rd_d = DataW'(1);
      end
    end else if (offset_q == RegConfig) begin
      if (size_q != SIZE_WORD) begin
        st_d = ST_BAD_SIZE;
      end else if (op_q == OP_READ) begin
        rd_d = ctrl_q;
      end else begin
        ctrl_we = 1'b1;
      end
    end else begin
      st_d = ST_UNHANDLED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.op;
      size_q   <= req_i.access_size;
      region_q <= req_i.region;
      offset_q <= req_i.offset;
      wdata_q  <= req_i.write_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_row_q    <= '0;
      ctrl_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= ST_OK;
    end else begin
      if (out_valid_q && rsp_o.ready && !finish) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          clr_row_q <= clr_row_q + RowW'(1);
          if (clr_row_q == LastRow) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (accept) begin
            state_q <= StLookup;
          end
        end
        StLookup: begin
          if (finish) begin
            out_valid_q  <= 1'b1;
            out_data_q   <= rd_d;
            out_status_q <= st_d;
            if (ctrl_clr) begin
              ctrl_q <= '0;
            end else if (ctrl_we) begin
              ctrl_q <= wdata_q;
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fpc_ram.sv
// ----------------------------------------------------------------------------
// fpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/fpc_checker.sv
// ----------------------------------------------------------------------------
// fpc_checker
// Port-level checks of the flash controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [fpc_pkg::DataW-1:0] rsp_read_data_i,
  input fpc_pkg::status_t        rsp_status_i
);
  import fpc_pkg::*;

  // one access in flight: no transfer on the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while an access is in flight");

  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |-> (rsp_read_data_i == '0))
    else $error("failed access returned nonzero data");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_read_data_i) && $stable(rsp_status_i))
    else $error("stalled response changed");

endmodule

bind flash_program_only_controller_top fpc_checker u_fpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_read_data_i (rsp_o.read_data),
  .rsp_status_i    (rsp_o.status)
);

`default_nettype wire
